@@ src/llrd_pkg.sv @@
// ----------------------------------------------------------------------------
// llrd_pkg
// shared types and constants of the llr bit deinterleaver
// ----------------------------------------------------------------------------
`default_nettype none

package llrd_pkg;

    localparam int SOFT_W  = 8;
    localparam int CMD_AW  = 16;
    localparam int BPS_W   = 4;
    localparam int SPB_W   = 13;
    localparam int CFG_W   = 13;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic REG_BPS = 1'b0;
    localparam logic REG_SPB = 1'b1;

    localparam logic [BPS_W-1:0] QM_2 = 4'd2;
    localparam logic [BPS_W-1:0] QM_4 = 4'd4;
    localparam logic [BPS_W-1:0] QM_6 = 4'd6;
    localparam logic [BPS_W-1:0] QM_8 = 4'd8;

    localparam logic [SPB_W-1:0] K_MAX = 13'd4096;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_STATUS
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CMD_AW-1:0] addr;
        logic [SOFT_W-1:0] data;
        logic              last;
        logic              zero;
    } t_cmd;

endpackage

`default_nettype wire

@@ src/llrd_queue.sv @@
// ----------------------------------------------------------------------------
// llrd_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module llrd_queue
    import llrd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd              r_buf [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/llrd_front.sv @@
// ----------------------------------------------------------------------------
// llrd_front
// configuration, item classification and interleaver address counters
// ----------------------------------------------------------------------------
`default_nettype none

module llrd_front
    import llrd_pkg::*;
#(
    parameter int MAX_LEN = 32768
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_accept,
    input  wire logic              i_mode,
    input  wire logic [SOFT_W-1:0] i_soft,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    localparam logic [16:0] LEN17 = 17'(MAX_LEN);
    localparam logic [16:0] CAP2  = 17'(MAX_LEN / 2);
    localparam logic [16:0] CAP4  = 17'(MAX_LEN / 4);
    localparam logic [16:0] CAP6  = 17'(MAX_LEN / 6);
    localparam logic [16:0] CAP8  = 17'(MAX_LEN / 8);

    logic [BPS_W-1:0]  r_bps, n_bps;
    logic [SPB_W-1:0]  r_spb, n_spb;
    logic [BPS_W-1:0]  r_qm, n_qm;
    logic [SPB_W-1:0]  r_k, n_k;
    logic [15:0]       r_e, n_e;
    logic [16:0]       cap;
    logic [SPB_W-1:0]  k_lim;

    logic [15:0]       r_wc, n_wc;
    logic [2:0]        r_bp, n_bp;
    logic [11:0]       r_sym, n_sym;
    logic [14:0]       r_rb, n_rb;
    logic [15:0]       r_rp, n_rp;
    logic              r_full, n_full;

    logic              bp_wrap;
    logic [2:0]        bp_eff;
    logic [14:0]       rb_eff;
    logic [15:0]       waddr;
    logic [3:0]        bp_inc;
    logic [15:0]       rb_inc;
    logic              fin;

    // live configuration and its derived block sizes
    always_comb begin
        n_bps = r_bps;
        n_spb = r_spb;
        if (i_cfg_we && (i_cfg_idx == REG_BPS)) begin
            n_bps = i_cfg_data[BPS_W-1:0];
        end
        if (i_cfg_we && (i_cfg_idx == REG_SPB)) begin
            n_spb = i_cfg_data[SPB_W-1:0];
        end
        case (n_bps)
            QM_4: begin
                n_qm = QM_4;
                cap  = CAP4;
            end
            QM_6: begin
                n_qm = QM_6;
                cap  = CAP6;
            end
            QM_8: begin
                n_qm = QM_8;
                cap  = CAP8;
            end
            default: begin
                n_qm = QM_2;
                cap  = CAP2;
            end
        endcase
        k_lim = (n_spb == '0) ? SPB_W'(1) : n_spb;
        if (k_lim > K_MAX) begin
            k_lim = K_MAX;
        end
        if ({4'b0, k_lim} > cap) begin
            k_lim = cap[SPB_W-1:0];
        end
        n_k = k_lim;
        n_e = 16'({12'b0, n_qm} * {3'b0, n_k});
    end

    // position (n mod Qm)*K + n/Qm from running counters
    always_comb begin
        bp_wrap = ({1'b0, r_bp} >= r_qm);
        bp_eff  = bp_wrap ? 3'd0 : r_bp;
        rb_eff  = bp_wrap ? 15'd0 : r_rb;
        waddr   = {1'b0, rb_eff} + {4'b0, r_sym};
        bp_inc  = {1'b0, bp_eff} + 4'd1;
        rb_inc  = {1'b0, rb_eff} + {3'b0, r_k};
        fin     = ({1'b0, r_rp} + 17'd1) >= {1'b0, r_e};

        n_wc   = r_wc;
        n_bp   = r_bp;
        n_sym  = r_sym;
        n_rb   = r_rb;
        n_rp   = r_rp;
        n_full = r_full;

        o_push      = 1'b0;
        o_cmd.kind  = CMD_STATUS;
        o_cmd.addr  = r_rp;
        o_cmd.data  = i_soft;
        o_cmd.last  = 1'b0;
        o_cmd.zero  = 1'b0;

        if (i_accept && !i_mode) begin
            if (!r_full) begin
                o_cmd.kind = CMD_WRITE;
                o_cmd.addr = waddr;
                o_push     = ({1'b0, waddr} < LEN17);
                if (bp_inc >= r_qm) begin
                    n_bp  = 3'd0;
                    n_rb  = 15'd0;
                    n_sym = r_sym + 12'd1;
                end else begin
                    n_bp = bp_inc[2:0];
                    n_rb = rb_inc[14:0];
                end
                n_wc   = r_wc + 16'd1;
                n_full = (n_wc >= r_e);
            end
        end else if (i_accept && i_mode) begin
            o_push = 1'b1;
            if (r_full) begin
                o_cmd.kind = CMD_READ;
                o_cmd.last = fin;
                o_cmd.zero = !({1'b0, r_rp} < LEN17);
                n_rp       = r_rp + 16'd1;
                if (fin) begin
                    n_wc   = '0;
                    n_bp   = '0;
                    n_sym  = '0;
                    n_rb   = '0;
                    n_rp   = '0;
                    n_full = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps  <= QM_2;
            r_spb  <= SPB_W'(1);
            r_qm   <= QM_2;
            r_k    <= SPB_W'(1);
            r_e    <= 16'd2;
            r_wc   <= '0;
            r_bp   <= '0;
            r_sym  <= '0;
            r_rb   <= '0;
            r_rp   <= '0;
            r_full <= 1'b0;
        end else begin
            r_bps  <= n_bps;
            r_spb  <= n_spb;
            r_qm   <= n_qm;
            r_k    <= n_k;
            r_e    <= n_e;
            r_wc   <= n_wc;
            r_bp   <= n_bp;
            r_sym  <= n_sym;
            r_rb   <= n_rb;
            r_rp   <= n_rp;
            r_full <= n_full;
        end
    end

endmodule

`default_nettype wire

@@ src/llrd_back.sv @@
// ----------------------------------------------------------------------------
// llrd_back
// soft bit store, read pipeline and output register
// ----------------------------------------------------------------------------
`default_nettype none

module llrd_back
    import llrd_pkg::*;
#(
    parameter int MAX_LEN = 32768
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_cmd               i_cmd,
    output logic                    o_pop,
    output logic                    o_tvalid,
    input  wire logic               i_tready,
    output logic [SOFT_W-1:0]       o_tdata,
    output logic                    o_tlast,
    output logic                    o_tuser
);

    localparam int AW = $clog2(MAX_LEN);

    logic [SOFT_W-1:0] r_mem [MAX_LEN];
    logic [SOFT_W-1:0] r_rd_data;

    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_last, r_s1_status, r_s1_zero;
    logic              r_out_valid;
    logic [SOFT_W-1:0] r_out_data;
    logic              r_out_last, r_out_status;

    logic              can_adv;
    logic              s1_free;
    logic              is_write;
    logic              pop_rd;

    assign can_adv  = !r_out_valid || i_tready;
    assign s1_free  = !r_s1_valid || can_adv;
    assign is_write = (i_cmd.kind == CMD_WRITE);
    assign o_pop    = i_valid && (is_write || s1_free);
    assign pop_rd   = o_pop && !is_write;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (pop_rd) begin
            n_s1_valid = 1'b1;
        end else if (can_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_write) begin
            r_mem[i_cmd.addr[AW-1:0]] <= i_cmd.data;
        end
        if (pop_rd && (i_cmd.kind == CMD_READ) && !i_cmd.zero) begin
            r_rd_data <= r_mem[i_cmd.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_rd) begin
            r_s1_last   <= i_cmd.last;
            r_s1_status <= (i_cmd.kind == CMD_STATUS);
            r_s1_zero   <= i_cmd.zero || (i_cmd.kind == CMD_STATUS);
        end
        if (can_adv) begin
            r_out_data   <= r_s1_zero ? '0 : r_rd_data;
            r_out_last   <= r_s1_last;
            r_out_status <= r_s1_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (can_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;
    assign o_tuser  = r_out_status;

endmodule

`default_nettype wire

@@ src/llr_bit_deinterleaver.sv @@
// ----------------------------------------------------------------------------
// llr_bit_deinterleaver
// block deinterleaver for signed 8-bit soft bits ahead of ldpc rate dematching
//
// input stream: tuser = mode (0 load soft bit, 1 read next), tdata = soft bit.
// a load of item n goes to position (n mod Qm)*K + n/Qm; loads into a full
// block are dropped and give no output item. each read gives one output item:
// tdata = soft bit in position order, tlast on the final bit of the block,
// tuser = status (1 when the block is not yet full, with tdata 0).
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 bits per symbol, 1 symbols per block); the user must write only while
// the block is idle, the block itself does not enforce it. throughput is one
// item per cycle while the command queue is not full; a read result passes
// the queue entry, then the store read register, then the output register.
// reset clears the counters and empties the queue and the output stage; the
// store content is not cleared and needs no clearing pass.
// when the receiver stalls, the output register holds its item, the read
// stage and the four-entry command queue fill, and then tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module llr_bit_deinterleaver
    import llrd_pkg::*;
#(
    parameter int MAX_LEN = 32768
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [SOFT_W-1:0] s_axis_tdata,   // soft_in [7:0]
    input  wire logic              s_axis_tuser,   // mode [0]
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [SOFT_W-1:0]      m_axis_tdata,   // soft_out [7:0]
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser    // status [0]
);

    logic accept;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    llrd_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_mode     (s_axis_tuser),
        .i_soft     (s_axis_tdata),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    llrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    llrd_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (q_cmd),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("status item carries data or last");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty command queue");

endmodule

`default_nettype wire

@@ bench/llrd_checker.sv @@
// ----------------------------------------------------------------------------
// llrd_checker
// watches both streams and the register port of the llr bit deinterleaver.
// a running copy of the block state predicts each read item, and the
// results are compared field by field against the output stream in order.
// ----------------------------------------------------------------------------
module llrd_checker
    import llrd_pkg::*;
#(
    parameter int MAX_LEN = 32768
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [SOFT_W-1:0] s_axis_tdata,   // soft_in [7:0]
    input  wire logic              s_axis_tuser,   // mode [0]
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [SOFT_W-1:0] m_axis_tdata,   // soft_out [7:0]
    input  wire logic              m_axis_tlast,
    input  wire logic              m_axis_tuser,   // status [0]
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_block_len
);

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NOT_FULL = 1'b1;

    typedef struct packed {
        logic [SOFT_W-1:0] llr;
        logic              last;
        logic              status;
    } t_llr_result;

    logic [SOFT_W-1:0] llr_mem [MAX_LEN];
    t_llr_result       read_results_q [$];

    logic [BPS_W-1:0]  qm_reg;
    logic [SPB_W-1:0]  k_reg;
    logic [15:0]       load_cnt;
    logic [11:0]       sym_idx;
    logic [15:0]       rd_ptr;
    int unsigned       bit_pos;
    int unsigned       row_off;
    bit                full;

    function automatic int unsigned active_qm(input logic [BPS_W-1:0] q);
        if (q == QM_4 || q == QM_6 || q == QM_8) begin
            return q;
        end
        return QM_2;
    endfunction

    function automatic int unsigned active_k(input logic [BPS_W-1:0] q,
                                             input logic [SPB_W-1:0] k);
        int unsigned kk;
        int unsigned cap;
        kk  = k;
        cap = MAX_LEN / active_qm(q);
        if (kk == 0) kk = 1;
        if (kk > K_MAX) kk = K_MAX;
        if (kk > cap) kk = cap;
        if (kk == 0) kk = 1;
        return kk;
    endfunction

    task automatic empty_block();
        load_cnt = '0;
        sym_idx  = '0;
        rd_ptr   = '0;
        bit_pos  = 0;
        row_off  = 0;
        full     = 1'b0;
    endtask

    task automatic predict_item(input logic mode, input logic [SOFT_W-1:0] llr_in);
        int unsigned qm;
        int unsigned k;
        int unsigned blen;
        int unsigned addr;
        t_llr_result r;
        qm   = active_qm(qm_reg);
        k    = active_k(qm_reg, k_reg);
        blen = qm * k;
        if (mode == 1'(CMD_WRITE)) begin
            if (!full) begin
                if (bit_pos >= qm) begin
                    bit_pos = 0;
                    row_off = 0;
                end
                addr = row_off + sym_idx;
                if (addr < MAX_LEN) llr_mem[addr] = llr_in;
                bit_pos++;
                row_off += k;
                if (bit_pos >= qm) begin
                    bit_pos = 0;
                    row_off = 0;
                    sym_idx = sym_idx + 1'b1;
                end
                load_cnt = load_cnt + 1'b1;
                if (load_cnt >= blen) full = 1'b1;
            end
        end else if (!full) begin
            r = '{llr: '0, last: 1'b0, status: ST_NOT_FULL};
            read_results_q.push_back(r);
        end else begin
            r.llr    = (rd_ptr < MAX_LEN) ? llr_mem[rd_ptr] : '0;
            r.last   = (rd_ptr + 1 >= blen);
            r.status = ST_OK;
            read_results_q.push_back(r);
            rd_ptr = rd_ptr + 1'b1;
            if (r.last) empty_block();
        end
    endtask

    task automatic compare_result();
        t_llr_result want;
        if (read_results_q.size() == 0) begin
            $error("unexpected output item: soft_out %0d, last %0b, status %0b",
                   $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
            o_fail_count++;
        end else begin
            want = read_results_q.pop_front();
            if (m_axis_tdata !== want.llr) begin
                $error("soft_out: expected %0d, actual %0d",
                       $signed(want.llr), $signed(m_axis_tdata));
                o_fail_count++;
            end
            if (m_axis_tlast !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
                o_fail_count++;
            end
            if (m_axis_tuser !== want.status) begin
                $error("status: expected %0b, actual %0b", want.status, m_axis_tuser);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            qm_reg = QM_2;
            k_reg  = SPB_W'(1);
            empty_block();
            read_results_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_BPS) qm_reg = i_cfg_data[BPS_W-1:0];
                else k_reg = i_cfg_data[SPB_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) compare_result();
        end
        o_pending   <= read_results_q.size();
        o_block_len <= active_qm(qm_reg) * active_k(qm_reg, k_reg);
    end

endmodule

@@ bench/llr_bit_deinterleaver_tb.sv @@
// ----------------------------------------------------------------------------
// llr_bit_deinterleaver_tb
// drives load and read items into the llr bit deinterleaver block by block:
// directed corner cases first, one longer block, then random
// blocks with random settings, under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module llr_bit_deinterleaver_tb;

    import llrd_pkg::*;

    localparam int MAX_LEN      = 32768;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int TOTAL_ITEMS  = 1100;
    localparam int TIMEOUT      = 10_000_000;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_idx     = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic [SOFT_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tready = 1'b1;
    wire logic              s_axis_tready;
    wire logic              m_axis_tvalid;
    wire logic [SOFT_W-1:0] m_axis_tdata;
    wire logic              m_axis_tlast;
    wire logic              m_axis_tuser;

    int fail_count;
    int pending;
    int block_len;
    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent = 0;

    always #5 i_clk = ~i_clk;

    llr_bit_deinterleaver #(
        .MAX_LEN(MAX_LEN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    llrd_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_block_len   (block_len)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic set_phase(input int ph);
        case (ph)
            0: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1: begin
                idle_pct  = 56;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 56;
            end
            default: begin
                idle_pct  = 27;
                stall_pct = 27;
            end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic mode, input logic [SOFT_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_soft(input logic [SOFT_W-1:0] value);
        send_item(1'(CMD_WRITE), value);
    endtask

    task automatic read_soft();
        send_item(1'(CMD_READ), SOFT_W'($urandom_range(255)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // whole block: configure, load, optional noise, optional pause, read out
    task automatic run_block(input logic [BPS_W-1:0] bps, input logic [SPB_W-1:0] spb,
                             input bit noisy, input bit hold);
        int n;
        write_reg(REG_BPS, CFG_W'(bps));
        write_reg(REG_SPB, CFG_W'(spb));
        n = block_len;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(15) == 0) read_soft();
            load_soft(SOFT_W'($urandom_range(255)));
        end
        if (noisy) repeat ($urandom_range(2)) load_soft(SOFT_W'($urandom_range(255)));
        if (hold) drain();
        for (int i = 0; i < n; i++) begin
            read_soft();
        end
    endtask

    initial begin
        logic [BPS_W-1:0] bps;
        logic [SPB_W-1:0] spb;
        int blk;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: read before full, extremes, load into full block
        read_soft();
        load_soft(8'h80);
        load_soft(8'h7F);
        load_soft(8'h00);
        read_soft();
        read_soft();

        // unsupported order acts as qpsk, interleave across two symbols
        write_reg(REG_BPS, CFG_W'(4'hF));
        write_reg(REG_SPB, CFG_W'(2));
        load_soft(8'h00);
        load_soft(8'hFF);
        load_soft(8'h01);
        load_soft(8'h55);
        repeat (4) read_soft();

        // settings changed with a block partly loaded
        write_reg(REG_BPS, CFG_W'(QM_4));
        write_reg(REG_SPB, CFG_W'(1));
        load_soft(8'hAA);
        write_reg(REG_BPS, CFG_W'(QM_2));
        load_soft(8'h33);
        read_soft();
        read_soft();

        // zero symbols acts as one
        run_block(QM_8, '0, 1'b0, 1'b0);
        run_block(QM_6, SPB_W'(3), 1'b1, 1'b1);

        // longer block, order 0 acts as qpsk
        set_phase(3);
        run_block('0, SPB_W'(40), 1'b0, 1'b0);

        blk = 0;
        while (items_sent < TOTAL_ITEMS) begin
            set_phase((blk / 3) % 4);
            case ($urandom_range(9))
                0: bps = BPS_W'($urandom_range(15));
                1, 2: bps = QM_2;
                3, 4: bps = QM_4;
                5, 6: bps = QM_6;
                default: bps = QM_8;
            endcase
            if ($urandom_range(9) == 0) spb = SPB_W'($urandom_range(30));
            else spb = SPB_W'($urandom_range(1, 6));
            run_block(bps, spb, $urandom_range(3) == 0, blk % 7 == 3);
            blk++;
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            if (pending != 0) $error("%0d read results never arrived", pending);
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ llr_bit_deinterleaver.f @@
src/llrd_pkg.sv
src/llrd_queue.sv
src/llrd_front.sv
src/llrd_back.sv
src/llr_bit_deinterleaver.sv
bench/llrd_checker.sv
bench/llr_bit_deinterleaver_tb.sv
